// ----- src/prs_pkg.sv -----
// Shared types and codes for the power rail supervisor.
package prs_pkg;

    // Request codes carried by an input transaction
    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_KILL_VOTE = 2'd1,
        REQ_MISSION   = 2'd2,
        REQ_TX_ON     = 2'd3
    } t_req;

    // Kill vote targets
    typedef enum logic [1:0] {
        UNIT_MAIN    = 2'd0,
        UNIT_MISSION = 2'd1,
        UNIT_RX      = 2'd2,
        UNIT_TX      = 2'd3
    } t_unit;

    // Action codes reported on a result transaction
    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_KILL_EVAL     = 3'd1,
        ACT_MAIN_START    = 3'd2,
        ACT_MISSION_START = 3'd3,
        ACT_COMM_START    = 3'd4,
        ACT_RX_KILL       = 3'd5,
        ACT_TX_KILL       = 3'd6
    } t_action;

    // Configuration register indexes
    localparam logic [2:0] REG_TICKS_PER_MINUTE   = 3'd0;
    localparam logic [2:0] REG_MINUTES_PER_HOUR   = 3'd1;
    localparam logic [2:0] REG_RESET_PERIOD_HOURS = 3'd2;
    localparam logic [2:0] REG_LONG_OFF_TICKS     = 3'd3;
    localparam logic [2:0] REG_SHORT_OFF_TICKS    = 3'd4;
    localparam logic [2:0] REG_RX_RESTART_TICKS   = 3'd5;

    // Rail enable bit positions
    localparam int RAIL_MAIN    = 0;
    localparam int RAIL_MISSION = 1;
    localparam int RAIL_RX      = 2;
    localparam int RAIL_TX      = 3;

    // Decoded command handed from front to back
    typedef struct packed {
        t_req       op;
        t_unit      unit;
        logic [2:0] vote_mask;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        t_action    action;
        logic [3:0] rails;
    } t_result;

endpackage

// ----- src/prs_front.sv -----
// Input side: decodes requests and buffers them in a two-entry command queue.
module prs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_req_type,
    input  logic [1:0]    i_unit,
    input  logic [1:0]    i_vote_slot,
    output logic          o_cmd_valid,
    output prs_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);

    prs_pkg::t_cmd r_q [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_count, n_count;
    prs_pkg::t_cmd w_dec;
    logic          w_push_ok;

    // Classify the incoming transaction
    always_comb begin
        w_dec.op   = prs_pkg::t_req'(i_req_type);
        w_dec.unit = prs_pkg::t_unit'(i_unit);
        unique case (i_vote_slot)
            2'd0:    w_dec.vote_mask = 3'b001;
            2'd1:    w_dec.vote_mask = 3'b010;
            2'd2:    w_dec.vote_mask = 3'b100;
            default: w_dec.vote_mask = 3'b000;
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign w_push_ok   = i_push && !o_full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count + {1'b0, w_push_ok} - {1'b0, i_cmd_take};
    end

    // Advance queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push_ok) r_wr_ptr <= !r_wr_ptr;
            if (i_cmd_take) r_rd_ptr <= !r_rd_ptr;
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_q[r_wr_ptr] <= w_dec;
    end

endmodule

// ----- src/prs_back.sv -----
// Execution side: holds supervisor state, runs one command a cycle while the result queue has room, queues results.
module prs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_cmd_valid,
    input  prs_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_empty,
    input  logic          i_pop,
    output prs_pkg::t_result o_result
);

    // Configuration registers
    logic [15:0] r_ticks_per_minute, r_rx_restart_ticks;
    logic [7:0]  r_minutes_per_hour, r_reset_period_hours;
    logic [7:0]  r_long_off_ticks, r_short_off_ticks;

    // Supervisor state
    logic [8:0]  r_main_off_timer, n_main_off_timer;
    logic [7:0]  r_main_wait_limit, n_main_wait_limit;
    logic        r_periodic_reason, n_periodic_reason;
    logic [15:0] r_uptime_ticks, n_uptime_ticks;
    logic [7:0]  r_uptime_minutes, n_uptime_minutes;
    logic [7:0]  r_uptime_hours, n_uptime_hours;
    logic [2:0]  r_main_votes, n_main_votes;
    logic [2:0]  r_mission_votes, n_mission_votes;
    logic [2:0]  r_rx_votes, n_rx_votes;
    logic [2:0]  r_tx_votes, n_tx_votes;
    logic        r_mission_pending, n_mission_pending;
    logic        r_tx_pending, n_tx_pending;
    logic [15:0] r_rx_off_timer, n_rx_off_timer;
    logic [3:0]  r_rails, n_rails;
    prs_pkg::t_action w_action;

    // Result queue
    prs_pkg::t_result r_res_q [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_pop_ok;

    assign o_empty    = (r_count == 2'd0);
    assign w_pop_ok   = i_pop && !o_empty;
    assign o_cmd_take = i_cmd_valid && ((r_count != 2'd2) || w_pop_ok);
    assign o_result   = r_res_q[r_rd_ptr];

    // Work out next state and action for the command at the head
    always_comb begin
        logic done;
        logic do_comm;
        logic rx_due;
        n_main_off_timer  = r_main_off_timer;
        n_main_wait_limit = r_main_wait_limit;
        n_periodic_reason = r_periodic_reason;
        n_uptime_ticks    = r_uptime_ticks;
        n_uptime_minutes  = r_uptime_minutes;
        n_uptime_hours    = r_uptime_hours;
        n_main_votes      = r_main_votes;
        n_mission_votes   = r_mission_votes;
        n_rx_votes        = r_rx_votes;
        n_tx_votes        = r_tx_votes;
        n_mission_pending = r_mission_pending;
        n_tx_pending      = r_tx_pending;
        n_rx_off_timer    = r_rx_off_timer;
        n_rails           = r_rails;
        w_action          = prs_pkg::ACT_NONE;
        done              = 1'b0;
        do_comm           = 1'b0;
        rx_due            = 1'b0;
        unique case (i_cmd.op)
            prs_pkg::REQ_TICK: begin
                // Main computer restart wait
                if (n_main_off_timer != 9'd0) begin
                    if (n_main_off_timer != 9'h1FF) n_main_off_timer = n_main_off_timer + 9'd1;
                    if (n_main_off_timer > {1'b0, n_main_wait_limit}) begin
                        n_rails[prs_pkg::RAIL_MAIN] = 1'b1;
                        n_main_off_timer  = 9'd0;
                        n_main_wait_limit = 8'd0;
                        w_action = prs_pkg::ACT_MAIN_START;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    // Uptime count and periodic reset votes
                    if (n_uptime_ticks != 16'hFFFF) n_uptime_ticks = n_uptime_ticks + 16'd1;
                    if (n_uptime_ticks > r_ticks_per_minute) begin
                        n_uptime_minutes = n_uptime_minutes + 8'd1;
                        n_uptime_ticks   = 16'd0;
                    end
                    if (n_uptime_minutes >= r_minutes_per_hour) begin
                        if (n_uptime_hours != 8'hFF) n_uptime_hours = n_uptime_hours + 8'd1;
                        n_uptime_minutes = 8'd0;
                        n_uptime_ticks   = 16'd0;
                    end
                    if (n_uptime_hours >= r_reset_period_hours) begin
                        n_main_votes      = 3'b111;
                        n_periodic_reason = 1'b1;
                        n_uptime_ticks    = 16'd0;
                        n_uptime_minutes  = 8'd0;
                        n_uptime_hours    = 8'd0;
                    end
                    // Pick one action by priority
                    if (n_main_votes[0] || n_mission_votes[0]) begin
                        if (n_mission_votes == 3'b111) n_rails[prs_pkg::RAIL_MISSION] = 1'b0;
                        n_mission_votes = 3'b000;
                        if (n_main_votes == 3'b111) begin
                            n_rails[prs_pkg::RAIL_MAIN] = 1'b0;
                            n_main_off_timer  = 9'd1;
                            n_main_wait_limit = n_periodic_reason ? r_long_off_ticks
                                                                  : r_short_off_ticks;
                        end
                        n_main_votes = 3'b000;
                        w_action = prs_pkg::ACT_KILL_EVAL;
                    end else if (n_mission_pending) begin
                        n_mission_pending = 1'b0;
                        n_mission_votes   = 3'b000;
                        n_rails[prs_pkg::RAIL_MISSION] = 1'b1;
                        w_action = prs_pkg::ACT_MISSION_START;
                    end else begin
                        if (n_rx_off_timer != 16'd0) begin
                            rx_due = (n_rx_off_timer > r_rx_restart_ticks);
                            if (n_rx_off_timer != 16'hFFFF) n_rx_off_timer = n_rx_off_timer + 16'd1;
                        end
                        if (rx_due || n_tx_pending) begin
                            do_comm = 1'b1;
                        end else if (n_rx_votes == 3'b111) begin
                            n_rails[prs_pkg::RAIL_RX] = 1'b0;
                            n_rx_off_timer = 16'd1;
                            n_rx_votes     = 3'b000;
                            w_action = prs_pkg::ACT_RX_KILL;
                        end else if (n_tx_votes == 3'b111) begin
                            n_rails[prs_pkg::RAIL_TX] = 1'b0;
                            n_tx_votes = 3'b000;
                            w_action = prs_pkg::ACT_TX_KILL;
                        end
                    end
                    // Communication start
                    if (do_comm) begin
                        if (n_rx_off_timer > r_rx_restart_ticks) begin
                            n_rails[prs_pkg::RAIL_RX] = 1'b1;
                            n_rx_off_timer = 16'd0;
                        end
                        if (n_tx_pending) begin
                            n_rails[prs_pkg::RAIL_TX] = 1'b1;
                            n_tx_pending = 1'b0;
                        end
                        w_action = prs_pkg::ACT_COMM_START;
                    end
                end
            end
            prs_pkg::REQ_KILL_VOTE: begin
                unique case (i_cmd.unit)
                    prs_pkg::UNIT_MAIN:    n_main_votes    = r_main_votes | i_cmd.vote_mask;
                    prs_pkg::UNIT_MISSION: n_mission_votes = r_mission_votes | i_cmd.vote_mask;
                    prs_pkg::UNIT_RX:      n_rx_votes      = r_rx_votes | i_cmd.vote_mask;
                    prs_pkg::UNIT_TX:      n_tx_votes      = r_tx_votes | i_cmd.vote_mask;
                    default:               n_tx_votes      = r_tx_votes;
                endcase
            end
            prs_pkg::REQ_MISSION: n_mission_pending = 1'b1;
            prs_pkg::REQ_TX_ON:   n_tx_pending      = 1'b1;
            default:              n_tx_pending      = r_tx_pending;
        endcase
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_minute   <= 16'd600;
            r_minutes_per_hour   <= 8'd60;
            r_reset_period_hours <= 8'd24;
            r_long_off_ticks     <= 8'd20;
            r_short_off_ticks    <= 8'd5;
            r_rx_restart_ticks   <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prs_pkg::REG_TICKS_PER_MINUTE:   r_ticks_per_minute   <= i_cfg_data;
                prs_pkg::REG_MINUTES_PER_HOUR:   r_minutes_per_hour   <= i_cfg_data[7:0];
                prs_pkg::REG_RESET_PERIOD_HOURS: r_reset_period_hours <= i_cfg_data[7:0];
                prs_pkg::REG_LONG_OFF_TICKS:     r_long_off_ticks     <= i_cfg_data[7:0];
                prs_pkg::REG_SHORT_OFF_TICKS:    r_short_off_ticks    <= i_cfg_data[7:0];
                prs_pkg::REG_RX_RESTART_TICKS:   r_rx_restart_ticks   <= i_cfg_data;
                default:                         r_rx_restart_ticks   <= r_rx_restart_ticks;
            endcase
        end
    end

    // Commit state when a command is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_off_timer  <= 9'd0;
            r_main_wait_limit <= 8'd0;
            r_periodic_reason <= 1'b0;
            r_uptime_ticks    <= 16'd0;
            r_uptime_minutes  <= 8'd0;
            r_uptime_hours    <= 8'd0;
            r_main_votes      <= 3'b000;
            r_mission_votes   <= 3'b000;
            r_rx_votes        <= 3'b000;
            r_tx_votes        <= 3'b000;
            r_mission_pending <= 1'b0;
            r_tx_pending      <= 1'b0;
            r_rx_off_timer    <= 16'd0;
            r_rails           <= 4'b0101;
        end else if (o_cmd_take) begin
            r_main_off_timer  <= n_main_off_timer;
            r_main_wait_limit <= n_main_wait_limit;
            r_periodic_reason <= n_periodic_reason;
            r_uptime_ticks    <= n_uptime_ticks;
            r_uptime_minutes  <= n_uptime_minutes;
            r_uptime_hours    <= n_uptime_hours;
            r_main_votes      <= n_main_votes;
            r_mission_votes   <= n_mission_votes;
            r_rx_votes        <= n_rx_votes;
            r_tx_votes        <= n_tx_votes;
            r_mission_pending <= n_mission_pending;
            r_tx_pending      <= n_tx_pending;
            r_rx_off_timer    <= n_rx_off_timer;
            r_rails           <= n_rails;
        end
    end

    // Advance result queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= r_count + {1'b0, o_cmd_take} - {1'b0, w_pop_ok};
            if (o_cmd_take) r_wr_ptr <= !r_wr_ptr;
            if (w_pop_ok) r_rd_ptr <= !r_rd_ptr;
        end
    end

    // Store result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) r_res_q[r_wr_ptr] <= '{action: w_action, rails: n_rails};
    end

endmodule

// ----- src/power_rail_supervisor_core.sv -----
// Top level of the power rail supervisor: front decoder, back executor, checks.
// Supervises main, mission, receiver and transmitter rails. Every accepted
// transaction yields exactly one result transaction: the action taken (ticks
// only) and the four rail enables after it. The block sustains one transaction
// per clock while results are popped. The command is first written into the
// two-entry command queue; when the executor takes it, it updates counters and
// votes and queues the result in a single step that sets the pace. Both queues
// hold two entries, so input keeps flowing for up to four transactions while
// results wait to be popped.
module power_rail_supervisor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_unit,
    input  logic [1:0]  i_vote_slot,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_action,
    output logic        o_main_power_on,
    output logic        o_mission_power_on,
    output logic        o_rx_power_on,
    output logic        o_tx_power_on
);

    logic             w_cmd_valid;
    logic             w_cmd_take;
    prs_pkg::t_cmd    w_cmd;
    prs_pkg::t_result w_result;

    prs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_unit      (i_unit),
        .i_vote_slot (i_vote_slot),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    prs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (w_result)
    );

    // Drive result fields
    assign o_action           = w_result.action;
    assign o_main_power_on    = w_result.rails[prs_pkg::RAIL_MAIN];
    assign o_mission_power_on = w_result.rails[prs_pkg::RAIL_MISSION];
    assign o_rx_power_on      = w_result.rails[prs_pkg::RAIL_RX];
    assign o_tx_power_on      = w_result.rails[prs_pkg::RAIL_TX];

    // A main start always leaves the main rail on
    a_main_start_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == prs_pkg::ACT_MAIN_START) |-> o_main_power_on)
        else $error("main start reported with main rail off");

    // A mission start always leaves the mission rail on
    a_mission_start_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_action == prs_pkg::ACT_MISSION_START) |-> o_mission_power_on)
        else $error("mission start reported with mission rail off");

    // Receiver and transmitter kills leave their rails off
    a_kill_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_action == prs_pkg::ACT_RX_KILL || o_action == prs_pkg::ACT_TX_KILL))
        |-> ((o_action == prs_pkg::ACT_RX_KILL) ? !o_rx_power_on : !o_tx_power_on))
        else $error("rail kill reported with rail still on");

    // The executor only takes a command that the front holds
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd_valid)
        else $error("command taken from empty queue");

endmodule
